### rtl/core/opc_pkg.sv
`default_nettype none

package opc_pkg;

	localparam int unsigned DEPTH     = 64;
	localparam int unsigned ADDR_W    = $clog2(DEPTH);
	localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
	localparam int unsigned WIDTH_W   = 16;
	localparam int unsigned TICK_W    = 20;
	localparam int unsigned MINP_W    = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 20;

	localparam logic [TICK_W-1:0]  TICK_MAX = {TICK_W{1'b1}};

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST  = 16'd300;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST  = 16'd2500;
	localparam logic [TICK_W-1:0]  SILENCE_RST    = 20'd25000;
	localparam logic [MINP_W-1:0]  MIN_PULSES_RST = 7'd45;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_WIDTH     = 2'd0,
		REG_MAX_WIDTH     = 2'd1,
		REG_SILENCE_TICKS = 2'd2,
		REG_MIN_PULSES    = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	typedef struct packed {
		logic             level;
		logic [WIDTH_W-1:0] width;
	} pulse_t;

endpackage

`default_nettype wire

### rtl/core/ook_pulse_capture_unit.sv
`default_nettype none

// On-off keyed pulse capture. One line sample is taken per tick (one input word
// per cycle while idle). Each level change closes a pulse; a pulse whose width
// lies strictly between min_width and max_width is written to a 64-entry pulse
// memory while it has room. Once more than silence_ticks ticks pass with no
// edge, a packet of at least min_pulses pulses is streamed out in order, one
// word per cycle when the output is not stalled (the memory read register is
// the output register), with last_in_run on the final pulse. While a packet
// streams, in_ready is low, so input is held off until the final word is taken,
// output stalls included. Widths are counted in ticks, the counter saturates at
// 2^20-1, and configuration writes take effect at once.
module ook_pulse_capture_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [opc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [opc_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            line_level,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 pulse_level,
	output logic [opc_pkg::WIDTH_W-1:0]          pulse_width,
	output logic                                 last_in_run
);

	logic [opc_pkg::WIDTH_W-1:0] min_width_q;
	logic [opc_pkg::WIDTH_W-1:0] max_width_q;
	logic [opc_pkg::TICK_W-1:0]  silence_q;
	logic [opc_pkg::MINP_W-1:0]  min_pulses_q;

	logic                        prev_level_q;
	logic [opc_pkg::TICK_W-1:0]  ticks_q;
	logic [opc_pkg::CNT_W-1:0]   cnt_q;
	logic [opc_pkg::CNT_W-1:0]   len_q;
	logic [opc_pkg::CNT_W-1:0]   rd_idx_q;
	logic                        out_valid_q;
	logic                        last_q;
	opc_pkg::pulse_t             rd_data_q;
	opc_pkg::state_t             state_q, state_d;

	opc_pkg::pulse_t mem [opc_pkg::DEPTH];

	logic                        accept;
	logic                        edge_seen;
	logic [opc_pkg::TICK_W-1:0]  elapsed;
	logic                        store;
	logic [opc_pkg::CNT_W-1:0]   cnt_new;
	logic [opc_pkg::TICK_W-1:0]  ticks_new;
	logic                        silence;
	logic                        start_dump;
	logic                        rd_en;
	logic                        rd_more;
	logic                        out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q  <= opc_pkg::MIN_WIDTH_RST;
			max_width_q  <= opc_pkg::MAX_WIDTH_RST;
			silence_q    <= opc_pkg::SILENCE_RST;
			min_pulses_q <= opc_pkg::MIN_PULSES_RST;
		end else if (cfg_we) begin
			case (opc_pkg::reg_idx_t'(cfg_idx))
				opc_pkg::REG_MIN_WIDTH:     min_width_q  <= cfg_data[opc_pkg::WIDTH_W-1:0];
				opc_pkg::REG_MAX_WIDTH:     max_width_q  <= cfg_data[opc_pkg::WIDTH_W-1:0];
				opc_pkg::REG_SILENCE_TICKS: silence_q    <= cfg_data[opc_pkg::TICK_W-1:0];
				opc_pkg::REG_MIN_PULSES:    min_pulses_q <= cfg_data[opc_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	// tick processing
	always_comb begin
		accept     = in_valid && in_ready;
		edge_seen  = line_level != prev_level_q;
		elapsed    = (ticks_q == opc_pkg::TICK_MAX) ? ticks_q : ticks_q + 1'b1;
		store      = edge_seen
			&& (elapsed > {{(opc_pkg::TICK_W-opc_pkg::WIDTH_W){1'b0}}, min_width_q})
			&& (elapsed < {{(opc_pkg::TICK_W-opc_pkg::WIDTH_W){1'b0}}, max_width_q})
			&& (cnt_q < opc_pkg::CNT_W'(opc_pkg::DEPTH));
		cnt_new    = cnt_q + opc_pkg::CNT_W'(store);
		ticks_new  = edge_seen ? '0 : elapsed;
		silence    = (cnt_new != '0) && (ticks_new > silence_q);
		start_dump = accept && silence && (cnt_new >= min_pulses_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			ticks_q      <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
		end else if (accept) begin
			prev_level_q <= line_level;
			ticks_q      <= ticks_new;
			cnt_q        <= silence ? '0 : cnt_new;
			if (start_dump) begin
				len_q <= cnt_new;
			end
		end
	end

	// pulse memory, read register doubles as output register
	always_ff @(posedge clk) begin
		if (accept && store) begin
			mem[cnt_q[opc_pkg::ADDR_W-1:0]] <= '{level: prev_level_q,
				width: elapsed[opc_pkg::WIDTH_W-1:0]};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q[opc_pkg::ADDR_W-1:0]];
			last_q    <= (rd_idx_q + 1'b1) == len_q;
		end
	end

	always_comb begin
		rd_more  = rd_idx_q < len_q;
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			opc_pkg::ST_IDLE: begin
				if (start_dump) begin
					state_d = opc_pkg::ST_DUMP;
				end
			end
			opc_pkg::ST_DUMP: begin
				if (!rd_more && out_free) begin
					state_d = opc_pkg::ST_IDLE;
				end
			end
			default: state_d = opc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			opc_pkg::ST_IDLE: in_ready = 1'b1;
			opc_pkg::ST_DUMP: rd_en    = rd_more && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= opc_pkg::ST_IDLE;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_dump) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pulse_level = rd_data_q.level;
	assign pulse_width = rd_data_q.width;
	assign last_in_run = last_q;

	// no input word while a packet word is pending
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while packet word pending");

	// count is cleared once a packet starts streaming
	a_cnt_clear_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == opc_pkg::ST_DUMP |-> cnt_q == '0)
		else $error("pulse count not cleared during dump");

	a_rd_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == opc_pkg::ST_DUMP |-> rd_idx_q <= len_q)
		else $error("read index past packet length");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= opc_pkg::CNT_W'(opc_pkg::DEPTH))
		else $error("pulse count exceeds depth");

	// nothing follows the final word of a packet
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_in_run |=> !out_valid)
		else $error("word after last_in_run");

endmodule

`default_nettype wire

### verif/ook_pulse_capture_unit_tb.sv
`timescale 1ns / 1ps

module ook_pulse_capture_unit_tb;

	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned LONG_STALL    = 300;

	typedef struct {
		bit                         level;
		bit [opc_pkg::WIDTH_W-1:0]  width;
		bit                         last;
	} pulse_word_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cfg_we     = 1'b0;
	logic [opc_pkg::CFG_IDX_W-1:0]  cfg_idx    = '0;
	logic [opc_pkg::CFG_DAT_W-1:0]  cfg_data   = '0;
	logic                           in_valid   = 1'b0;
	logic                           in_ready;
	logic                           line_level = 1'b0;
	logic                           out_valid;
	logic                           out_ready  = 1'b0;
	logic                           pulse_level;
	logic [opc_pkg::WIDTH_W-1:0]    pulse_width;
	logic                           last_in_run;

	ook_pulse_capture_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.line_level  (line_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pulse_level (pulse_level),
		.pulse_width (pulse_width),
		.last_in_run (last_in_run)
	);

	always #5 clk = ~clk;

	// capture predictor: settings and state
	bit [opc_pkg::WIDTH_W-1:0] win_lo     = opc_pkg::MIN_WIDTH_RST;
	bit [opc_pkg::WIDTH_W-1:0] win_hi     = opc_pkg::MAX_WIDTH_RST;
	bit [opc_pkg::TICK_W-1:0]  quiet_end  = opc_pkg::SILENCE_RST;
	bit [opc_pkg::MINP_W-1:0]  pkt_min    = opc_pkg::MIN_PULSES_RST;
	bit                        line_prev  = 1'b0;
	bit [opc_pkg::TICK_W-1:0]  since_edge = '0;
	int unsigned               stored     = 0;
	bit                        level_mem[opc_pkg::DEPTH];
	bit [opc_pkg::WIDTH_W-1:0] width_mem[opc_pkg::DEPTH];

	pulse_word_t pending_pulses[$];

	int unsigned mismatches   = 0;
	int unsigned words_out    = 0;
	int unsigned ticks_sent   = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on      = 1'b1;
	logic        holding      = 1'b0;
	event        hold_out;

	function automatic void capture_tick(bit lvl);
		bit [opc_pkg::TICK_W-1:0] elapsed;
		pulse_word_t              w;
		elapsed = since_edge;
		if (elapsed != opc_pkg::TICK_MAX)
			elapsed++;
		if (lvl != line_prev) begin
			if (elapsed > win_lo && elapsed < win_hi && stored < opc_pkg::DEPTH) begin
				level_mem[stored] = line_prev;
				width_mem[stored] = elapsed[opc_pkg::WIDTH_W-1:0];
				stored++;
			end
			since_edge = '0;
			line_prev  = lvl;
		end else begin
			since_edge = elapsed;
		end
		// silence closes the packet; it goes out only if long enough
		if (stored > 0 && since_edge > quiet_end) begin
			if (stored >= pkt_min) begin
				for (int i = 0; i < stored; i++) begin
					w.level = level_mem[i];
					w.width = width_mem[i];
					w.last  = (i + 1 == stored);
					pending_pulses.push_back(w);
				end
			end
			stored = 0;
		end
	endfunction

	function automatic void log_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
	endfunction

	always @(posedge clk) begin
		pulse_word_t want;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (arst_n && out_valid && out_ready) begin
			words_out++;
			if (pending_pulses.size() == 0) begin
				log_mismatch("unexpected word, width", 0, pulse_width);
			end else begin
				want = pending_pulses.pop_front();
				if (pulse_level !== want.level)
					log_mismatch("pulse_level", want.level, pulse_level);
				if (pulse_width !== want.width)
					log_mismatch("pulse_width", want.width, pulse_width);
				if (last_in_run !== want.last)
					log_mismatch("last_in_run", want.last, last_in_run);
			end
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !holding && !(idle_on && $urandom_range(99) < 20);
	end

	// long receiver stall, counted here
	initial forever begin
		@(hold_out);
		holding <= 1'b1;
		repeat (LONG_STALL) @(posedge clk);
		holding <= 1'b0;
	end

	task automatic send_tick(bit lvl);
		while (idle_on && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		line_level <= lvl;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		capture_tick(lvl);
	endtask

	task automatic send_hold(int unsigned n);
		repeat (n) send_tick(line_prev);
	endtask

	// flip the line and keep it for w ticks; the width shows at the next flip
	task automatic send_pulse(int unsigned w);
		send_tick(!line_prev);
		send_hold(w - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(int unsigned lo, int unsigned hi, int unsigned quiet,
			int unsigned minp);
		int unsigned       vals[4];
		opc_pkg::reg_idx_t idx;
		settle();
		vals = '{lo, hi, quiet, minp};
		idx  = opc_pkg::REG_MIN_WIDTH;
		for (int i = 0; i < 4; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idx;
			cfg_data <= opc_pkg::CFG_DAT_W'(vals[i]);
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we    <= 1'b0;
		win_lo    = opc_pkg::WIDTH_W'(lo);
		win_hi    = opc_pkg::WIDTH_W'(hi);
		quiet_end = opc_pkg::TICK_W'(quiet);
		pkt_min   = opc_pkg::MINP_W'(minp);
	endtask

	// reset settings: short pulses stay below the default window
	task automatic test_reset_settings();
		repeat (8) send_pulse($urandom_range(1, 5));
		send_hold(10);
	endtask

	task automatic test_window_edges();
		configure(3, 8, 9, 4);
		send_pulse(3);
		send_pulse(4);
		send_pulse(7);
		send_pulse(8);
		send_pulse(5);
		send_pulse(6);
		send_pulse(12);
	endtask

	task automatic test_min_pulses();
		// zero minimum: a single pulse is a packet
		configure(0, 50, 4, 0);
		send_pulse(2);
		send_pulse(6);
		// minimum beyond the buffer: cleared, nothing out
		configure(0, 50, 4, 127);
		repeat (5) send_pulse($urandom_range(1, 3));
		send_pulse(6);
		// full buffer drops the overflow pulses
		configure(0, 50, 4, opc_pkg::DEPTH);
		repeat (66) send_pulse($urandom_range(1, 2));
		send_pulse(6);
	endtask

	task automatic test_empty_window();
		configure(5, 5, 4, 1);
		send_pulse(4);
		send_pulse(5);
		send_pulse(6);
		send_pulse(6);
		configure(65535, 0, 4, 1);
		send_pulse(5);
		send_pulse(1);
		send_pulse(6);
	endtask

	task automatic test_silence_zero();
		configure(0, 65535, 0, 1);
		repeat (6) send_pulse(1);
		send_hold(3);
	endtask

	// both sides run with no idle cycles
	task automatic test_no_idle();
		idle_on = 1'b0;
		configure(1, 6, 5, 2);
		repeat (12) send_pulse($urandom_range(1, 6));
		send_hold(7);
		settle();
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		configure(0, 20, 4, 1);
		repeat (20) send_pulse($urandom_range(1, 4));
		-> hold_out;
		send_pulse(8);
		send_hold(4);
		settle();
	endtask

	task automatic test_random_packets();
		int unsigned tick_base, lo, hi, quiet, minp, n, w, phase;
		tick_base = ticks_sent;
		phase     = 0;
		while (ticks_sent - tick_base < 120 && phase < 40) begin
			lo    = $urandom_range(0, 2);
			hi    = lo + $urandom_range(2, 6);
			quiet = hi + $urandom_range(0, 4);
			minp  = $urandom_range(0, 4);
			configure(lo, hi, quiet, minp);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(7) == 0) begin
					// noise
					repeat ($urandom_range(5, 15)) send_tick(1'($urandom_range(1, 0)));
				end else begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						if ($urandom_range(9) < 8)
							w = $urandom_range(lo + 1, hi - 1);
						else
							w = $urandom_range(1, hi + 2);
						send_pulse(w);
					end
					send_hold(quiet + $urandom_range(1, 4));
				end
			end
			phase++;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_window_edges();
		test_min_pulses();
		test_empty_window();
		test_silence_zero();
		test_no_idle();
		test_backpressure();
		test_random_packets();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_pulses.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
